[src/nudft_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nudft_pkg
// Shared constants, codes, state type and fixed-point helpers for the
// nonuniform DFT evaluator.
// ----------------------------------------------------------------------------
package nudft_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int TRIG_BITS   = 16;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int COUNT_W     = $clog2(MAX_SAMPLES) + 1;

  localparam int TIME_W  = 32;
  localparam int FLUX_W  = 24;
  localparam int FREQ_W  = 32;
  localparam int SUM_W   = 52;
  localparam int ACC_W   = 64;
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int Q30_W   = PROD_W - 30;
  localparam int TRIG_W  = 16;

  // Keep only the top TRIG_BITS of the phase
  localparam logic [31:0] PHASE_KEEP = ~((32'd1 << (32 - TRIG_BITS)) - 32'd1);
  localparam logic [31:0] QUARTER    = 32'h4000_0000;
  localparam logic [30:0] Q30_ONE    = 31'h4000_0000;

  // Quarter-wave sine polynomial coefficients, Q30
  localparam logic signed [MUL_W-1:0] C1 = 33'sd1686629713;
  localparam logic signed [MUL_W-1:0] C3 = -33'sd693598668;
  localparam logic signed [MUL_W-1:0] C5 = 33'sd85569306;
  localparam logic signed [MUL_W-1:0] C7 = -33'sd5026995;
  localparam logic signed [MUL_W-1:0] C9 = 33'sd172272;

  localparam logic signed [ACC_W-1:0] OUT_MAX = 64'sd2251799813685247;
  localparam logic signed [ACC_W-1:0] OUT_MIN = -64'sd2251799813685248;

  // Command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FEW      = 2'd1;
  localparam logic [1:0] STAT_UNSORTED = 2'd2;
  localparam logic [1:0] STAT_OVERFLOW = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_LOAD, S_PHASE, S_ANGLE, S_MX2, S_WX2,
    S_MH, S_WH, S_MS, S_WS, S_MF, S_WF, S_DONE
  } seq_state_t;

  // Drop 30 fraction bits, truncating toward zero
  function automatic logic signed [Q30_W-1:0] q30(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] mag;
    logic [Q30_W-1:0]  sh;
    mag = p[PROD_W-1] ? (~p + 1'b1) : p;
    sh  = mag[PROD_W-1:30];
    return p[PROD_W-1] ? signed'(~sh + 1'b1) : signed'(sh);
  endfunction

  // Horner coefficient for step 0..3
  function automatic logic signed [MUL_W-1:0] horner_coef(input logic [1:0] idx);
    case (idx)
      2'd0:    return C7;
      2'd1:    return C5;
      2'd2:    return C3;
      default: return C1;
    endcase
  endfunction

  // Clamp a wide sum to the output range
  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    c = (v > OUT_MAX) ? OUT_MAX : ((v < OUT_MIN) ? OUT_MIN : v);
    return c[SUM_W-1:0];
  endfunction

endpackage

[src/nudft_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nudft_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nudft_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/nonuniform_dft_evaluator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonuniform_dft_evaluator
// Direct DFT of an irregularly sampled series on one shared multiplier.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): cmd 0 loads one sample (time, flux);
// last_sample closes the set, and the next load starts a new set. cmd 1
// queries one frequency and returns one transaction on the output channel
// (out_valid/out_stall): real_sum, imag_sum, status.
// A query runs the stored samples one after another through a single
// 33x33 multiplier: phase product, quarter-wave polynomial for cosine and
// sine (six Q30 products each) and two flux products, with a register
// after every multiply. A query with a nonzero status or no stored samples
// goes straight to its result. in_stall is high for the whole query. A
// finished result waits in the output register while out_stall is high;
// loads are still taken meanwhile.
// Reset clears the sequencer and set flags; sample memories are not
// cleared, only written entries are read.
// ----------------------------------------------------------------------------
module nonuniform_dft_evaluator (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   cmd,
  input  logic [nudft_pkg::TIME_W-1:0]           sample_time,
  input  logic signed [nudft_pkg::FLUX_W-1:0]    sample_flux,
  input  logic                                   last_sample,
  input  logic [nudft_pkg::FREQ_W-1:0]           frequency,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [nudft_pkg::SUM_W-1:0]     real_sum,
  output logic signed [nudft_pkg::SUM_W-1:0]     imag_sum,
  output logic [1:0]                             status
);
  import nudft_pkg::*;

  seq_state_t state, state_next;

  // Set bookkeeping
  logic [COUNT_W-1:0] sample_count;
  logic [TIME_W-1:0]  first_time;
  logic [TIME_W-1:0]  previous_time;
  logic               distinct_seen;
  logic               order_ok;
  logic               set_closed;
  logic               overflow_seen;

  // Datapath registers
  logic [ADDR_W-1:0]              k;
  logic [FREQ_W-1:0]              freq;
  logic signed [FLUX_W-1:0]       fl;
  logic [31:0]                    phase;
  logic                           which;
  logic [1:0]                     quad;
  logic [30:0]                    x;
  logic [30:0]                    x2;
  logic signed [MUL_W-1:0]        r;
  logic [1:0]                     hidx;
  logic signed [TRIG_W-1:0]       trig;
  logic signed [PROD_W-1:0]       prod;
  logic signed [ACC_W-1:0]        acc_re;
  logic signed [ACC_W-1:0]        acc_im;
  logic [1:0]                     q_status;

  logic signed [MUL_W-1:0] op_a, op_b;
  logic [TIME_W-1:0]       rd_time;
  logic [FLUX_W-1:0]       rd_flux;

  logic in_fire, load_fire, query_fire, out_load;
  logic load_room;
  logic [COUNT_W-1:0] load_idx;
  logic [1:0]         q_status_now;
  logic [31:0]        ang;
  logic signed [Q30_W-1:0] prod_q30;
  logic signed [Q30_W-1:0] sine_r;
  logic [COUNT_W-1:0] k_ext;

  assign in_stall   = (state != S_IDLE);
  assign in_fire    = in_valid && !in_stall;
  assign load_fire  = in_fire && (cmd == CMD_LOAD);
  assign query_fire = in_fire && (cmd == CMD_QUERY);
  assign out_load   = (state == S_DONE) && (!out_valid || !out_stall);
  assign k_ext      = {1'b0, k};

  // Effective count once a new set has started
  assign load_idx  = set_closed ? '0 : sample_count;
  assign load_room = (load_idx < COUNT_W'(MAX_SAMPLES));

  // Status priority: too few distinct, then unsorted, then overflow
  always_comb begin
    if (!distinct_seen) q_status_now = STAT_FEW;
    else if (!order_ok) q_status_now = STAT_UNSORTED;
    else if (overflow_seen) q_status_now = STAT_OVERFLOW;
    else q_status_now = STAT_OK;
  end

  // Sample memories
  nudft_ram #(.WIDTH(TIME_W), .DEPTH(MAX_SAMPLES)) u_time_ram (
    .clk   (clk),
    .we    (load_fire && load_room),
    .waddr (load_idx[ADDR_W-1:0]),
    .wdata (sample_time),
    .raddr (k),
    .rdata (rd_time)
  );

  nudft_ram #(.WIDTH(FLUX_W), .DEPTH(MAX_SAMPLES)) u_flux_ram (
    .clk   (clk),
    .we    (load_fire && load_room),
    .waddr (load_idx[ADDR_W-1:0]),
    .wdata (sample_flux),
    .raddr (k),
    .rdata (rd_flux)
  );

  // Track the current set during loads
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count  <= '0;
      first_time    <= '0;
      previous_time <= '0;
      distinct_seen <= 1'b0;
      order_ok      <= 1'b1;
      set_closed    <= 1'b1;
      overflow_seen <= 1'b0;
    end else if (load_fire) begin
      if (set_closed) begin
        distinct_seen <= 1'b0;
        order_ok      <= 1'b1;
        overflow_seen <= 1'b0;
      end
      if (load_room) begin
        if (load_idx == '0) begin
          first_time <= sample_time;
        end else begin
          if (sample_time != first_time) distinct_seen <= 1'b1;
          if (previous_time > sample_time) order_ok <= 1'b0;
        end
        previous_time <= sample_time;
        sample_count  <= load_idx + 1'b1;
      end else begin
        sample_count  <= load_idx;
        overflow_seen <= 1'b1;
      end
      set_closed <= last_sample;
    end
  end

  // Select operands of the shared multiplier
  always_comb begin
    case (state)
      S_LOAD:  begin op_a = signed'({1'b0, freq});    op_b = signed'({1'b0, rd_time}); end
      S_MX2:   begin op_a = signed'({2'b0, x});       op_b = signed'({2'b0, x}); end
      S_MH:    begin op_a = r;                        op_b = signed'({2'b0, x2}); end
      S_MS:    begin op_a = r;                        op_b = signed'({2'b0, x}); end
      S_MF:    begin op_a = MUL_W'(fl);               op_b = MUL_W'(trig); end
      default: begin op_a = '0;                       op_b = '0; end
    endcase
  end

  assign prod_q30 = q30(prod);
  assign ang      = which ? phase : (phase + QUARTER);
  assign sine_r   = (prod_q30 + Q30_W'(16384)) >>> 15;

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (query_fire) begin
          state_next = ((q_status_now != STAT_OK) || (sample_count == '0)) ? S_DONE : S_READ;
        end
      end
      S_READ:  state_next = S_LOAD;
      S_LOAD:  state_next = S_PHASE;
      S_PHASE: state_next = S_ANGLE;
      S_ANGLE: state_next = S_MX2;
      S_MX2:   state_next = S_WX2;
      S_WX2:   state_next = S_MH;
      S_MH:    state_next = S_WH;
      S_WH:    state_next = (hidx == 2'd3) ? S_MS : S_MH;
      S_MS:    state_next = S_WS;
      S_WS:    state_next = S_MF;
      S_MF:    state_next = S_WF;
      S_WF: begin
        if (!which) state_next = S_ANGLE;
        else if (k_ext + 1'b1 == sample_count) state_next = S_DONE;
        else state_next = S_READ;
      end
      S_DONE:  state_next = out_load ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: one multiply or one update per cycle
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    case (state)
      S_IDLE: begin
        if (query_fire) begin
          freq     <= frequency;
          q_status <= q_status_now;
          k        <= '0;
          acc_re   <= '0;
          acc_im   <= '0;
        end
      end
      S_LOAD:  fl <= rd_flux;
      S_PHASE: begin
        phase <= prod[31:0] & PHASE_KEEP;
        which <= 1'b0;
      end
      S_ANGLE: begin
        quad <= ang[31:30];
        x    <= ang[30] ? (Q30_ONE - {1'b0, ang[29:0]}) : {1'b0, ang[29:0]};
      end
      S_WX2: begin
        x2   <= prod_q30[30:0];
        r    <= C9;
        hidx <= 2'd0;
      end
      S_WH: begin
        r    <= horner_coef(hidx) + prod_q30[MUL_W-1:0];
        hidx <= hidx + 1'b1;
      end
      S_WS: begin
        if (prod_q30 <= 0) trig <= '0;
        else if (sine_r > Q30_W'(32767)) trig <= quad[1] ? -16'sd32767 : 16'sd32767;
        else trig <= quad[1] ? -sine_r[TRIG_W-1:0] : sine_r[TRIG_W-1:0];
      end
      S_WF: begin
        if (!which) begin
          acc_re <= acc_re + ACC_W'(prod);
          which  <= 1'b1;
        end else begin
          acc_im <= acc_im + ACC_W'(prod);
          k      <= k + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status   <= q_status;
      real_sum <= (q_status == STAT_OK) ? sat_sum(acc_re) : '0;
      imag_sum <= (q_status == STAT_OK) ? sat_sum(-acc_im) : '0;
    end
  end

  // Error results carry zero sums
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STAT_OK) |-> (real_sum == '0) && (imag_sum == '0))
    else $error("nonzero status with nonzero sums");

  // Sample index stays inside the stored set while summing
  a_k_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (k_ext < sample_count))
    else $error("sample index past stored count");

  // A new result appears only from the done state
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result presented outside done state");

  // Sum path runs only on a clean set
  a_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_MF) |-> (q_status == STAT_OK))
    else $error("summing with error status");

endmodule
